// ----- rtl/knn_pkg.sv -----
`timescale 1ns / 1ps

package knn_pkg;

  localparam int K_MAX   = 8;
  localparam int COORD_W = 16;
  localparam int MAG_W   = 16;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIST_W  = 34;
  localparam int CNT_W   = $clog2(K_MAX + 1);
  localparam int NC_W    = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X        = 2'd0,
    REG_QUERY_Y        = 2'd1,
    REG_NEIGHBOR_COUNT = 2'd2
  } cfg_reg_t;

endpackage

// ----- rtl/knn_two_class_classifier.sv -----
`timescale 1ns / 1ps

// Two-class k-nearest-neighbor classifier. Labelled training points stream in at one item per
// cycle while in_stall is low; each is taken through a four-stage distance pipeline (input
// register, absolute differences, squares, squared distance) and then inserted into a sorted
// list of the K_MAX nearest points by parallel compare-and-shift, so the sustained rate is one
// item per clock when nothing stalls. An item marked last produces one result: the majority
// label of the first k entries (tie goes to red) and the number of entries that voted; the
// list is then cleared. The pipeline stalls only when a last item reaches the list while the
// previous result is still waiting on the output; the items behind it then wait and the input
// is held off once every stage is full. The query registers and k are written through the
// cfg port (always ready) by the user while the block is idle; the block does not enforce it.
module knn_two_class_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [knn_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [knn_pkg::COORD_W-1:0] in_point_y,
  input  logic                              in_label_red,
  input  logic                              in_last_point,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_class_red,
  output logic [knn_pkg::NC_W-1:0]          out_neighbors_found,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [knn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [knn_pkg::COORD_W-1:0]       cfg_data
);
  import knn_pkg::*;

  // configuration
  logic signed [COORD_W-1:0] query_x_r, query_y_r;
  logic [NC_W-1:0]           neighbor_count_r;

  // pipeline stages
  logic                      s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic                      s1_label_r, s2_label_r, s3_label_r, s4_label_r;
  logic                      s1_last_r,  s2_last_r,  s3_last_r,  s4_last_r;
  logic signed [COORD_W-1:0] s1_x_r, s1_y_r;
  logic [MAG_W-1:0]          s2_ax_r, s2_ay_r;
  logic [SQ_W-1:0]           s3_sqx_r, s3_sqy_r;
  dist_t                     s4_dist_r;

  logic signed [COORD_W:0]   diff_x, diff_y;
  logic [COORD_W:0]          abs_x, abs_y;

  // neighbor list
  dist_t                     best_distance_r [K_MAX];
  dist_t                     best_distance_nxt [K_MAX];
  logic [K_MAX-1:0]          best_label_r, best_label_nxt;
  logic [K_MAX-1:0]          slot_valid_r, slot_valid_nxt;
  dist_t                     ins_distance [K_MAX];
  logic [K_MAX-1:0]          ins_label, ins_valid, le;

  // vote and output
  cnt_t                      k_eff, found_cnt, red_cnt;
  logic                      vote_red;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_class_red_r;
  logic [NC_W-1:0]           out_found_r;

  // handshake
  logic adv4, rdy4, rdy3, rdy2, rdy1;
  logic load1, load2, load3, load4, load_out;

  assign adv4     = s4_valid_r && (!s4_last_r || !out_valid_r || !out_stall);
  assign rdy4     = !s4_valid_r || adv4;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign load1    = in_valid && rdy1;
  assign load2    = s1_valid_r && rdy2;
  assign load3    = s2_valid_r && rdy3;
  assign load4    = s3_valid_r && rdy4;
  assign load_out = adv4 && s4_last_r;

  assign in_stall  = !rdy1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r        <= '0;
      query_y_r        <= '0;
      neighbor_count_r <= NC_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_QUERY_X:        query_x_r        <= cfg_data;
        REG_QUERY_Y:        query_y_r        <= cfg_data;
        REG_NEIGHBOR_COUNT: neighbor_count_r <= cfg_data[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // absolute differences
  always_comb begin
    diff_x = {s1_x_r[COORD_W-1], s1_x_r} - {query_x_r[COORD_W-1], query_x_r};
    diff_y = {s1_y_r[COORD_W-1], s1_y_r} - {query_y_r[COORD_W-1], query_y_r};
    abs_x  = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : diff_x;
    abs_y  = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : diff_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
      if (rdy4) s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_x_r     <= in_point_x;
      s1_y_r     <= in_point_y;
      s1_label_r <= in_label_red;
      s1_last_r  <= in_last_point;
    end
    if (load2) begin
      s2_ax_r    <= abs_x[MAG_W-1:0];
      s2_ay_r    <= abs_y[MAG_W-1:0];
      s2_label_r <= s1_label_r;
      s2_last_r  <= s1_last_r;
    end
    if (load3) begin
      s3_sqx_r   <= s2_ax_r * s2_ax_r;
      s3_sqy_r   <= s2_ay_r * s2_ay_r;
      s3_label_r <= s2_label_r;
      s3_last_r  <= s2_last_r;
    end
    if (load4) begin
      s4_dist_r  <= DIST_W'(s3_sqx_r) + DIST_W'(s3_sqy_r);
      s4_label_r <= s3_label_r;
      s4_last_r  <= s3_last_r;
    end
  end

  // compare-and-shift insertion, equal distances stay ahead
  genvar g;
  generate
    for (g = 0; g < K_MAX; g++) begin : g_slot
      assign le[g] = slot_valid_r[g] && (best_distance_r[g] <= s4_dist_r);
      if (g == 0) begin : g_head
        always_comb begin
          if (le[g]) begin
            ins_distance[g] = best_distance_r[g];
            ins_label[g]    = best_label_r[g];
            ins_valid[g]    = slot_valid_r[g];
          end else begin
            ins_distance[g] = s4_dist_r;
            ins_label[g]    = s4_label_r;
            ins_valid[g]    = 1'b1;
          end
        end
      end else begin : g_tail
        always_comb begin
          if (le[g]) begin
            ins_distance[g] = best_distance_r[g];
            ins_label[g]    = best_label_r[g];
            ins_valid[g]    = slot_valid_r[g];
          end else if (le[g-1]) begin
            ins_distance[g] = s4_dist_r;
            ins_label[g]    = s4_label_r;
            ins_valid[g]    = 1'b1;
          end else begin
            ins_distance[g] = best_distance_r[g-1];
            ins_label[g]    = best_label_r[g-1];
            ins_valid[g]    = slot_valid_r[g-1];
          end
        end
      end
    end
  endgenerate

  // vote over the first k entries of the updated list
  always_comb begin
    if (neighbor_count_r == '0) begin
      k_eff = cnt_t'(1);
    end else if (CNT_W'(neighbor_count_r) > cnt_t'(K_MAX)) begin
      k_eff = cnt_t'(K_MAX);
    end else begin
      k_eff = CNT_W'(neighbor_count_r);
    end
    found_cnt = '0;
    red_cnt   = '0;
    for (int i = 0; i < K_MAX; i++) begin
      if (ins_valid[i] && (cnt_t'(i) < k_eff)) begin
        found_cnt = found_cnt + cnt_t'(1);
        red_cnt   = red_cnt + cnt_t'(ins_label[i]);
      end
    end
    vote_red = {red_cnt, 1'b0} >= {1'b0, found_cnt};
  end

  always_comb begin
    best_distance_nxt = best_distance_r;
    best_label_nxt    = best_label_r;
    slot_valid_nxt    = slot_valid_r;
    if (adv4) begin
      best_distance_nxt = ins_distance;
      best_label_nxt    = ins_label;
      slot_valid_nxt    = s4_last_r ? '0 : ins_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_distance_r <= best_distance_nxt;
    best_label_r    <= best_label_nxt;
    if (load_out) begin
      out_class_red_r <= vote_red;
      out_found_r     <= NC_W'(found_cnt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_class_red       = out_class_red_r;
  assign out_neighbors_found = out_found_r;

  // occupied slots always form a prefix of the list
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((slot_valid_r >> 1) & ~slot_valid_r) == '0)
    else $error("neighbor list has a gap");

  // list stays sorted by distance
  generate
    for (g = 1; g < K_MAX; g++) begin : g_sorted
      a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid_r[g] |-> (best_distance_r[g-1] <= best_distance_r[g]))
        else $error("neighbor list out of order");
    end
  endgenerate

  // a result clears the list
  a_clear_after_vote: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (slot_valid_r == '0))
    else $error("list not cleared after vote");

  // at least one neighbor votes and no more than the list holds
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r != '0) && (CNT_W'(out_found_r) <= cnt_t'(K_MAX)))
    else $error("neighbor count out of range");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load_out)
    else $error("result overwritten while stalled");

endmodule
